// ----- sv/rtle_pkg.sv -----
// Package for the resident table with largest-first eviction.
// Holds field widths, operation and status codes, the slot record layout,
// the controller state type and the command/status structs. No dependencies.
package rtle_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 16;

  // Field widths
  localparam int ID_W    = 16;
  localparam int SIZE_W  = 16;
  localparam int START_W = 16;
  localparam int SWAP_W  = 4;
  localparam int STAMP_W = 32;
  localparam int MEM_W   = 16;
  localparam int CNT_OUT_W = 5;
  localparam int PCT_W   = 16;
  localparam int STAT_W  = 2;

  // Stream payload widths (packed fields padded to whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 80;

  // Scale of the usage share
  localparam int PCT_SCALE = 100;

  // Maximum swap count
  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EVICT  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One stored table entry
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SWAP_W-1:0]  swaps;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic [ID_W-1:0]    id;
  } slot_t;

  // Controller states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_APPLY = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
    logic mul;
    logic div;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/resident_table_largest_evict_core.sv -----
// Resident process table with largest-first eviction, oldest entry on ties.
//
// The in_ channel carries one request per beat: insert (tuser 0) stores the
// entry in the lowest free slot, evict (tuser 1) removes the largest entry.
// The out_ channel returns one result beat per request: status in tuser,
// the evicted entry, the resident count and the used share of memory.
// cfg_wr_en/cfg_wr_data set the memory size used as the share divisor.
//
// A request runs a scan of every slot through the slot RAM's single read
// port, then compare drain, commit and scaling, then the one-bit-per-cycle
// usage divider; no new request is accepted until its result is loaded.
// A held result sits in the output register while the next request is
// accepted and processed; a stalled receiver only holds the block once the
// next result is ready to load.
// Reset empties the table, zeroes the entry stamp and sets the memory size
// to 1; the slot RAM needs no clearing.
// Depends on rtle_pkg, rtle_ctrl, rtle_dp and rtle_ram.
module resident_table_largest_evict_core
  import rtle_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // proc_id[15:0], proc_size[31:16], place_start[47:32], swap_count_in[51:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_id[15:0], out_size[31:16], out_start[47:32], out_swaps[51:48],
  // resident_count[56:52], usage_percent[72:57]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [MEM_W-1:0]      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  rtle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtle_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Load a result only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over an unread beat");

  // A loaded result shows up on the port
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

  // Commit exactly once per request
  a_apply_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> !cmd.apply)
    else $error("table commit repeated");

  // Accept no beat while a request is in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!cmd.scan && !cmd.div && !cmd.apply))
    else $error("request accepted during processing");

endmodule

// ----- sv/rtle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependency; used for the slot record store.
module rtle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/rtle_dp.sv -----
// Datapath of the resident table: slot store, valid bits, scan compare,
// running totals, usage divider and the output register.
// Depends on rtle_pkg and rtle_ram.
module rtle_dp
  import rtle_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_wr_en,
  input  logic [MEM_W-1:0]      cfg_wr_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]     out_tuser
);

  localparam int IW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);
  localparam int TW = SIZE_W + SW;
  localparam int NW = TW + 8;
  localparam int CW = (NW > 33) ? NW : 33;
  localparam int QW = PCT_W;
  localparam int KW = $clog2(QW);

  // Latched request
  logic               op_r;
  logic [ID_W-1:0]    req_id_r;
  logic [SIZE_W-1:0]  req_size_r;
  logic [START_W-1:0] req_start_r;
  logic [SWAP_W-1:0]  req_swaps_r;

  // Table state
  logic [SLOTS-1:0]   valid_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [SW-1:0]      count_r;
  logic [TW-1:0]      total_r;
  logic [MEM_W-1:0]   mem_total_r;

  // Scan state
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      idx_d_r;
  logic               cmp_v_r;
  logic               best_found_r;
  logic [IW-1:0]      best_idx_r;
  slot_t              best_r;
  logic               free_found_r;
  logic [IW-1:0]      free_idx_r;

  // Result and divider state
  status_t            res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic [SIZE_W-1:0]  res_size_r;
  logic [START_W-1:0] res_start_r;
  logic [SWAP_W-1:0]  res_swaps_r;
  logic [CW-1:0]      rem_r;
  logic [CW-1:0]      dvs_r;
  logic [QW-1:0]      quo_r;
  logic [KW-1:0]      div_cnt_r;
  logic               zero_r;
  logic               sat_r;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0]     out_tuser_r;

  // RAM ports
  logic          wr_en;
  slot_t         wr_slot;
  logic [IW-1:0] wr_addr;
  logic [$bits(slot_t)-1:0] rd_data;
  slot_t         rd_slot;

  logic          slot_vld;
  logic          better;
  logic          div_ge;
  logic [CW-1:0] scaled;
  logic [CW-1:0] sat_lim;
  logic [31:0]   cnt_ext;
  logic [PCT_W-1:0] pct;

  assign rd_slot  = slot_t'(rd_data);
  assign slot_vld = valid_r[idx_d_r];
  assign better   = !best_found_r || (rd_slot.size > best_r.size) ||
                    ((rd_slot.size == best_r.size) && (rd_slot.stamp < best_r.stamp));

  // Insert writes the lowest free slot
  assign wr_en   = cmd.apply && (op_r == OP_INSERT) && free_found_r;
  assign wr_addr = free_idx_r;
  always_comb begin
    wr_slot       = '0;
    wr_slot.id    = req_id_r;
    wr_slot.size  = req_size_r;
    wr_slot.start = (count_r == '0) ? '0 : req_start_r;
    wr_slot.swaps = req_swaps_r;
    wr_slot.stamp = stamp_r;
  end

  rtle_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Usage arithmetic
  assign scaled  = CW'(total_r) * CW'(PCT_SCALE) + CW'(mem_total_r) - CW'(1);
  assign sat_lim = CW'(mem_total_r) << QW;
  assign div_ge  = rem_r >= dvs_r;

  // Status to the controller
  assign sts.scan_last = (idx_r == IW'(SLOTS - 1));
  assign sts.div_last  = (div_cnt_r == '0);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r        <= in_tuser;
      req_id_r    <= in_tdata[15:0];
      req_size_r  <= in_tdata[31:16];
      req_start_r <= in_tdata[47:32];
      req_swaps_r <= in_tdata[51:48];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_total_r <= MEM_W'(1);
    end else if (cfg_wr_en) begin
      mem_total_r <= cfg_wr_data;
    end
  end

  // Scan address, compare stage flags and table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cmp_v_r      <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      stamp_r      <= '0;
      count_r      <= '0;
      total_r      <= '0;
    end else begin
      cmp_v_r <= cmd.scan;
      if (cmd.start) begin
        idx_r        <= '0;
        best_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmp_v_r) begin
        if (slot_vld && better) begin
          best_found_r <= 1'b1;
        end
        if (!slot_vld && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      // Commit the insert or the eviction
      if (cmd.apply) begin
        if (op_r == OP_INSERT) begin
          if (free_found_r) begin
            valid_r[free_idx_r] <= 1'b1;
            stamp_r <= stamp_r + STAMP_W'(1);
            count_r <= count_r + SW'(1);
            total_r <= total_r + TW'(req_size_r);
          end
        end else if (best_found_r) begin
          valid_r[best_idx_r] <= 1'b0;
          count_r <= count_r - SW'(1);
          total_r <= total_r - TW'(best_r.size);
        end
      end
    end
  end

  // Track the best candidate and the first free slot
  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    if (cmp_v_r) begin
      if (slot_vld && better) begin
        best_idx_r <= idx_d_r;
        best_r     <= rd_slot;
      end
      if (!slot_vld && !free_found_r) begin
        free_idx_r <= idx_d_r;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status_r <= STAT_OK;
      res_id_r     <= '0;
      res_size_r   <= '0;
      res_start_r  <= '0;
      res_swaps_r  <= '0;
      if (op_r == OP_INSERT) begin
        if (!free_found_r) begin
          res_status_r <= STAT_FULL;
        end
      end else if (!best_found_r) begin
        res_status_r <= STAT_EMPTY;
      end else begin
        res_id_r    <= best_r.id;
        res_size_r  <= best_r.size;
        res_start_r <= best_r.start;
        res_swaps_r <= (best_r.swaps == SWAP_MAX) ? SWAP_MAX : best_r.swaps + SWAP_W'(1);
      end
    end
  end

  // Ceil division by restoring steps, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r     <= scaled;
      dvs_r     <= CW'(mem_total_r) << (QW - 1);
      quo_r     <= '0;
      div_cnt_r <= KW'(QW - 1);
      zero_r    <= (total_r == '0);
    end else if (cmd.div) begin
      if (div_cnt_r == KW'(QW - 1)) begin
        sat_r <= (rem_r >= sat_lim);
      end
      if (div_ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r     <= {quo_r[QW-2:0], div_ge};
      dvs_r     <= dvs_r >> 1;
      div_cnt_r <= div_cnt_r - KW'(1);
    end
  end

  assign cnt_ext = 32'(count_r);
  assign pct     = zero_r ? '0 : (sat_r ? '1 : quo_r);

  // Output register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tuser_r <= res_status_r;
      out_tdata_r <= {7'b0, pct, cnt_ext[CNT_OUT_W-1:0], res_swaps_r,
                      res_start_r, res_size_r, res_id_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- sv/rtle_ctrl.sv -----
// Controller of the resident table: sequences accept, slot scan, commit,
// usage division and output load. Depends on rtle_pkg.
module rtle_ctrl
  import rtle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
